// ===== rtl/bca_pkg.sv =====
`timescale 1ns / 1ps
package bca_pkg;
  localparam int FIELD_W = 32;
  localparam int TID_W   = 16;
  localparam int TC_W    = 16;
  localparam int IN_W    = 2 * FIELD_W + TID_W;
  localparam logic [TC_W-1:0] TC_RESET = TC_W'(1);
endpackage

// ===== rtl/block_cyclic_affinity_size_core.sv =====
`timescale 1ns / 1ps
// throughput: one item per cycle unless the output stalls; an input register
// feeds two bit-per-stage restoring dividers (SIZE_BITS stages each), followed by
// select, multiply and output stages
// a stall on the output freezes the whole pipeline; nothing is lost or repeated
// reset (synchronous, rst_n low) clears all valid bits and sets thread_count to 1
module block_cyclic_affinity_size_core #(
  parameter int SIZE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration: thread_count, taken only while no item is in flight
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bca_pkg::TC_W-1:0]    cfg_data,
  // input items
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // total_size [31:0], block_bytes [63:32], thread_id [79:64]
  input  logic [bca_pkg::IN_W-1:0]    in_tdata,
  // result items
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // affinity_bytes [31:0]
  output logic [bca_pkg::FIELD_W-1:0] out_tdata
);
  import bca_pkg::*;

  localparam int W  = SIZE_BITS;
  localparam int NS = 2 * W;   // divider stages

  typedef struct packed {
    logic [W-1:0]     total;
    logic [W-1:0]     blk;
    logic [W-1:0]     a;      // dividend shifting out, quotient shifting in
    logic [W-1:0]     r;      // first divider remainder
    logic [W-1:0]     tail;   // partial tail block bytes
    logic [TC_W-1:0]  r2;     // second divider remainder (cutoff)
    logic [TID_W-1:0] tid;
    logic             degen;
  } stage_t;

  logic [TC_W-1:0] tc_r;
  logic            en;
  logic            busy;

  stage_t s_r [0:NS];
  logic   v_r [0:NS];

  // select stage
  logic [W-1:0]     mq_r,  mq_nxt;
  logic [W-1:0]     sblk_r, stot_r, stail_r;
  logic [TID_W-1:0] stid_r;
  logic             seq_r, sdeg_r, sv_r;
  // multiply stage
  logic [W-1:0]     prod_r, mtot_r, mtail_r;
  logic [2*W-1:0]   prod_full;
  logic [TID_W-1:0] mtid_r;
  logic             meq_r, mdeg_r, mv_r;
  // output
  logic [FIELD_W-1:0] out_r, out_nxt;
  logic [W-1:0]       res;
  logic               ov_r;

  // whole pipeline advances together unless the output is held
  assign en        = !ov_r || out_tready;
  assign in_tready = en;

  // thread count feeds every second-divider stage, so it only changes when empty
  always_comb begin
    busy = sv_r || mv_r || ov_r;
    for (int k = 0; k <= NS; k++) begin
      busy = busy || v_r[k];
    end
  end
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= TC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tc_r <= (cfg_data == '0) ? TC_RESET : cfg_data;
    end
  end

  // input register: mask sizes to SIZE_BITS and flag degenerate layouts
  logic [63:0]  tot64, blk64;
  logic [W-1:0] tot_in, blk_in;
  assign tot64  = 64'(in_tdata[FIELD_W-1:0]);
  assign blk64  = 64'(in_tdata[2*FIELD_W-1:FIELD_W]);
  assign tot_in = tot64[W-1:0];
  assign blk_in = blk64[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0].total <= tot_in;
      s_r[0].blk   <= blk_in;
      s_r[0].a     <= tot_in;
      s_r[0].r     <= '0;
      s_r[0].tail  <= '0;
      s_r[0].r2    <= '0;
      s_r[0].tid   <= in_tdata[IN_W-1:2*FIELD_W];
      s_r[0].degen <= (blk_in == '0) || (tot_in == '0) || (blk_in >= tot_in);
    end
  end

  // divider stages: first total/block_bytes, then nblocks/thread_count
  for (genvar i = 1; i <= NS; i++) begin : g_div
    stage_t s_nxt;
    logic [W:0]      rt1;
    logic [TC_W:0]   rt2;
    logic            q1, q2;
    stage_t          p;

    assign p   = (i == W + 1) ? stage_t'{total: s_r[i-1].total, blk: s_r[i-1].blk,
                                  a: s_r[i-1].a, r: s_r[i-1].r, tail: s_r[i-1].r,
                                  r2: '0, tid: s_r[i-1].tid,
                                  degen: s_r[i-1].degen}
                              : s_r[i-1];
    assign rt1 = {p.r, p.a[W-1]};
    assign q1  = rt1 >= {1'b0, p.blk};
    assign rt2 = {p.r2, p.a[W-1]};
    assign q2  = rt2 >= {1'b0, tc_r};

    always_comb begin
      s_nxt = p;
      if (i <= W) begin
        s_nxt.r = q1 ? W'(rt1 - {1'b0, p.blk}) : rt1[W-1:0];
        s_nxt.a = {p.a[W-2:0], q1};
      end else begin
        s_nxt.r2 = q2 ? TC_W'(rt2 - {1'b0, tc_r}) : rt2[TC_W-1:0];
        s_nxt.a  = {p.a[W-2:0], q2};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i] <= s_nxt;
      end
    end
  end

  // select: threads below the cutoff get one extra block
  assign mq_nxt = s_r[NS].a + W'(TID_W'(s_r[NS].tid) < s_r[NS].r2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
      mv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      sv_r <= v_r[NS];
      mv_r <= sv_r;
      ov_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mq_r    <= mq_nxt;
      sblk_r  <= s_r[NS].blk;
      stot_r  <= s_r[NS].total;
      stail_r <= s_r[NS].tail;
      stid_r  <= s_r[NS].tid;
      seq_r   <= s_r[NS].tid == s_r[NS].r2;
      sdeg_r  <= s_r[NS].degen;
    end
  end

  // multiply: share in blocks times block size
  assign prod_full = mq_r * sblk_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_full[W-1:0];
      mtot_r  <= stot_r;
      mtail_r <= stail_r;
      mtid_r  <= stid_r;
      meq_r   <= seq_r;
      mdeg_r  <= sdeg_r;
    end
  end

  // output: thread at the cutoff also takes the tail; degenerate gives all to thread 0
  logic [63:0] res64;
  always_comb begin
    if (mdeg_r) begin
      res = (mtid_r == '0) ? mtot_r : '0;
    end else begin
      res = prod_r + (meq_r ? mtail_r : '0);
    end
    res64   = 64'(res);
    out_nxt = res64[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  a_tc_nonzero: assert property (@(posedge clk) disable iff (!rst_n) tc_r != '0)
    else $error("thread count register holds zero");
  a_rem1: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[W] && !s_r[W].degen |-> s_r[W].r < s_r[W].blk)
    else $error("first divider remainder not below block size");
  a_rem2: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS] |-> s_r[NS].r2 < tc_r)
    else $error("cutoff not below thread count");
endmodule

// ===== tb/sv/block_cyclic_affinity_size_core_test.sv =====
`timescale 1ns / 1ps
module block_cyclic_affinity_size_core_test;
  import bca_pkg::*;

  localparam int LATENCY = 68;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TC_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [FIELD_W-1:0] out_tdata;

  // predictor copy of the thread count register
  logic [TC_W-1:0] thread_cnt = TC_RESET;
  logic [FIELD_W-1:0] affinity_q[$];
  int errors = 0;
  int cycles = 0;
  bit idle_off = 1'b0;

  block_cyclic_affinity_size_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // bytes of the object owned by one thread, blocks dealt round-robin
  function automatic logic [FIELD_W-1:0] affinity_bytes(
      input logic [31:0] total, input logic [31:0] blk, input logic [15:0] tid);
    logic [63:0] t, nblk, cut, fl;
    t = (thread_cnt == 0) ? 64'd1 : 64'(thread_cnt);
    if (blk == 0 || total == 0 || blk >= total)
      return (tid == 0) ? total : 32'd0;
    nblk = 64'(total) / 64'(blk);
    cut = nblk % t;
    fl = (nblk / t) * 64'(blk);
    if (64'(tid) < cut) return 32'(((nblk + t - 1) / t) * 64'(blk));
    if (64'(tid) > cut) return 32'(fl);
    return 32'(fl + (64'(total) - nblk * 64'(blk)));
  endfunction

  // result checker and random back-pressure on the output
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (affinity_q.size() == 0) report("result with nothing expected");
      else begin
        logic [FIELD_W-1:0] want;
        want = affinity_q.pop_front();
        if (out_tdata !== want)
          report($sformatf("affinity_bytes got %0d want %0d", out_tdata, want));
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (idle_off) out_tready <= 1'b1;
      else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else out_tready <= 1'b1;
    end
  end

  // one query; valid may stay high back to back
  task automatic send_query(input logic [31:0] total, input logic [31:0] blk,
                            input logic [15:0] tid);
    int gap;
    if (!idle_off && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {tid, blk, total};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    affinity_q.push_back(affinity_bytes(total, blk, tid));
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (affinity_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic write_thread_count(input logic [TC_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thread_cnt = (v == 0) ? TC_W'(1) : v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // field extremes, degenerate layouts, cutoff thread, out-of-range ids and extreme thread counts
  task automatic test_directed;
    write_thread_count(16'd4);
    send_query(32'd0, 32'd0, 16'd0);
    send_query(32'd0, 32'd7, 16'd1);
    send_query(32'd100, 32'd0, 16'd0);
    send_query(32'd100, 32'd0, 16'd2);
    send_query(32'd100, 32'd100, 16'd0);
    send_query(32'd100, 32'd200, 16'd3);
    send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    send_query(32'hFFFF_FFFF, 32'd1, 16'd0);
    send_query(32'hFFFF_FFFF, 32'd1, 16'd3);
    for (int i = 0; i < 6; i++) send_query(32'd23, 32'd4, 16'(i));
    send_query(32'd23, 32'd4, 16'hFFFF);
    send_query(32'hFFFF_FFFE, 32'hFFFF_FFFD, 16'd1);
    send_query(32'hAAAA_5555, 32'h5555_AAAA, 16'hAAAA);
    drain();
    // a zero write falls back to one thread
    write_thread_count(16'd0);
    send_query(32'd23, 32'd4, 16'd0);
    send_query(32'd23, 32'd4, 16'd1);
    drain();
    write_thread_count(16'hFFFF);
    send_query(32'hFFFF_FFFF, 32'd1, 16'hFFFE);
    send_query(32'hFFFF_FFFF, 32'd1, 16'hFFFF);
    send_query(32'hFFFF_FFFF, 32'd1, 16'h0000);
    drain();
  endtask

  task automatic test_random(input int n);
    logic [31:0] total, blk;
    logic [15:0] tid;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin total = $urandom; blk = $urandom; end
        1: begin total = $urandom_range(1, 4000); blk = $urandom_range(1, 64); end
        2: begin total = $urandom; blk = $urandom_range(1, 1 << 16); end
        default: begin total = $urandom_range(0, 50); blk = $urandom_range(0, 60); end
      endcase
      tid = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(0, thread_cnt + 1));
      send_query(total, blk, tid);
    end
    drain();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    write_thread_count(16'd1);
    test_random(150);
    write_thread_count(16'd7);
    test_random(200);
    write_thread_count(16'($urandom_range(2, 300)));
    test_random(200);
    write_thread_count(16'hFFFF);
    test_random(100);
    // last part at full rate
    idle_off = 1'b1;
    write_thread_count(16'd3);
    test_random(150);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== block_cyclic_affinity_size_core.f =====
rtl/bca_pkg.sv
rtl/block_cyclic_affinity_size_core.sv
tb/sv/block_cyclic_affinity_size_core_test.sv
